FILE: sv/lzw_encoder_variable_width_macros.svh
// ----------------------------------------------------------------------------
// lzw encoder assertion macros
// shared check forms for the lzw encoder
// ----------------------------------------------------------------------------
`ifndef LZW_ENCODER_VARIABLE_WIDTH_MACROS_SVH
`define LZW_ENCODER_VARIABLE_WIDTH_MACROS_SVH

// same-cycle implication, disabled in reset
`define LZWE_CHECK(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define LZWE_CHECK_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/lzwe_pkg.sv
// ----------------------------------------------------------------------------
// lzwe_pkg
// constants and types of the variable-width lzw encoder
// ----------------------------------------------------------------------------
package lzwe_pkg;

    localparam int DEFAULT_MAX_CODE_BITS = 12;
    localparam int FIRST_FREE            = 256;
    localparam int MIN_WIDTH             = 8;
    localparam int CODE_W                = 12;
    localparam int WIDTH_W               = 4;
    localparam int CFG_W                 = 4;
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd12;

    typedef struct packed {
        logic               stream_end;
        logic [WIDTH_W-1:0] code_width;
        logic [CODE_W-1:0]  code;
    } out_item_t;

endpackage

FILE: sv/lzw_encoder_variable_width.sv
// ----------------------------------------------------------------------------
// lzw_encoder_variable_width
// variable-width lzw encoder with a hashed string table in block memory
// ----------------------------------------------------------------------------
// channel   dir  tdata                      tuser/tlast
// s_        in   data_byte[7:0]             tlast = final_byte
// m_        out  code[11:0], code_width     tlast = stream_end
// cfg_wr_   in   max_code_bits[3:0]         -
//
// a byte with an empty prefix is taken as the prefix; otherwise each hash
// probe reads the hash memory, then the string memory; usually one probe
// a final byte adds a flush step for the flush code
// after reset a clearing pass sweeps all 2^(MAX_CODE_BITS+1) hash memory
// entries; no transfer is taken on s_ meanwhile
// results wait in a 4-entry output queue; m_ stalls never lose a code
// ----------------------------------------------------------------------------
`include "lzw_encoder_variable_width_macros.svh"

module lzw_encoder_variable_width
    import lzwe_pkg::*;
#(
    parameter int MAX_CODE_BITS = DEFAULT_MAX_CODE_BITS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CFG_W-1:0]  cfg_wr_data,   // max_code_bits
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,       // data_byte
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,       // code[11:0], code_width[15:12]
    output logic              m_tlast
);

    localparam int CW          = MAX_CODE_BITS;
    localparam int NF_W        = MAX_CODE_BITS + 1;
    localparam int HB          = MAX_CODE_BITS + 1;
    localparam int KEY_W       = CW + 8;
    localparam int SLOT_W      = KEY_W + CW;
    localparam int TABLE_DEPTH = 1 << CW;
    localparam int HASH_DEPTH  = 1 << HB;
    localparam int FIFO_DEPTH  = 4;
    localparam int BW          = $clog2(NF_W + 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD1   = 3'd2;
    localparam logic [2:0] S_RD2   = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CW-1:0]     prefix_reg, prefix_next;
    logic              prefix_valid_reg, prefix_valid_next;
    logic [NF_W-1:0]   next_free_reg, next_free_next;
    logic [CFG_W-1:0]  max_bits_reg;
    logic [7:0]        byte_reg, byte_next;
    logic              fin_reg, fin_next;
    logic [HB-1:0]     probe_reg, probe_next;
    logic [HB-1:0]     clr_reg, clr_next;

    logic [SLOT_W-1:0] hash_mem [HASH_DEPTH];
    logic [KEY_W-1:0]  str_mem  [TABLE_DEPTH];
    logic [SLOT_W-1:0] hash_q;
    logic [KEY_W-1:0]  str_q;

    logic              hash_re, hash_we, str_re, str_we;
    logic [HB-1:0]     hash_raddr, hash_waddr;
    logic [SLOT_W-1:0] hash_wdata;
    logic [CW-1:0]     str_raddr, str_waddr;
    logic [KEY_W-1:0]  str_wdata;

    out_item_t         fifo_reg [FIFO_DEPTH];
    logic [1:0]        rd_ptr_reg, wr_ptr_reg;
    logic [2:0]        cnt_reg;
    logic              push, pop;
    out_item_t         push_item;

    logic [KEY_W-1:0]  key;
    logic [CW-1:0]     slot_code;
    logic [KEY_W-1:0]  slot_key;
    logic              slot_valid, slot_match, can_grow, insert;
    logic [BW-1:0]     eff_bits;
    logic [NF_W-1:0]   cap;
    logic [WIDTH_W-1:0] cur_width;
    logic              accept;

    function automatic logic [BW-1:0] width_of(input logic [NF_W-1:0] nf);
        logic [NF_W-1:0] n;
        logic [BW-1:0]   bits;
        n    = nf - NF_W'(1);
        bits = '0;
        for (int i = 0; i < NF_W; i++) begin
            if (n[i]) begin
                bits = BW'(i + 1);
            end
        end
        if (bits < BW'(MIN_WIDTH)) begin
            bits = BW'(MIN_WIDTH);
        end
        return bits;
    endfunction

    function automatic logic [HB-1:0] hash_of(input logic [CW-1:0] p, input logic [7:0] b);
        return HB'(p) ^ (HB'(b) << (HB - 8));
    endfunction

    // effective capacity
    always_comb begin
        if ({1'b0, max_bits_reg} < 5'(MIN_WIDTH)) begin
            eff_bits = BW'(MIN_WIDTH);
        end else if (BW'(max_bits_reg) > BW'(MAX_CODE_BITS)) begin
            eff_bits = BW'(MAX_CODE_BITS);
        end else begin
            eff_bits = BW'(max_bits_reg);
        end
        cap = NF_W'(1) << eff_bits;
    end

    assign key        = {prefix_reg, byte_reg};
    assign slot_code  = hash_q[CW-1:0];
    assign slot_key   = hash_q[SLOT_W-1:CW];
    assign slot_valid = (slot_code >= CW'(FIRST_FREE)) && (NF_W'(slot_code) < next_free_reg)
                        && (str_q == slot_key);
    assign slot_match = slot_valid && (slot_key == key);
    assign can_grow   = next_free_reg < cap;
    assign insert     = (state_reg == S_RD2) && !slot_valid && can_grow;
    assign cur_width  = WIDTH_W'(width_of(next_free_reg));

    assign s_tready = (state_reg == S_IDLE) && (cnt_reg <= 3'(FIFO_DEPTH - 2));
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next        = state_reg;
        prefix_next       = prefix_reg;
        prefix_valid_next = prefix_valid_reg;
        next_free_next    = next_free_reg;
        byte_next         = byte_reg;
        fin_next          = fin_reg;
        probe_next        = probe_reg;
        clr_next          = clr_reg;
        hash_re           = 1'b0;
        hash_raddr        = probe_reg;
        hash_we           = 1'b0;
        hash_waddr        = probe_reg;
        hash_wdata        = {key, CW'(next_free_reg)};
        str_re            = 1'b0;
        str_raddr         = slot_code;
        str_we            = 1'b0;
        str_waddr         = CW'(next_free_reg);
        str_wdata         = key;
        push              = 1'b0;
        push_item         = '{stream_end: 1'b0, code_width: cur_width,
                              code: CODE_W'(prefix_reg)};

        unique case (state_reg)
            S_CLEAR: begin
                hash_we    = 1'b1;
                hash_waddr = clr_reg;
                hash_wdata = '0;
                clr_next   = clr_reg + HB'(1);
                if (clr_reg == HB'(HASH_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    byte_next = s_tdata;
                    fin_next  = s_tlast;
                    if (!prefix_valid_reg) begin
                        prefix_next       = CW'(s_tdata);
                        prefix_valid_next = 1'b1;
                        if (s_tlast) begin
                            state_next = S_FLUSH;
                        end
                    end else begin
                        hash_re    = 1'b1;
                        hash_raddr = hash_of(prefix_reg, s_tdata);
                        probe_next = hash_of(prefix_reg, s_tdata);
                        state_next = S_RD1;
                    end
                end
            end
            S_RD1: begin
                str_re     = 1'b1;
                state_next = S_RD2;
            end
            S_RD2: begin
                if (slot_match) begin
                    prefix_next = slot_code;
                    state_next  = fin_reg ? S_FLUSH : S_IDLE;
                end else if (slot_valid) begin
                    hash_re    = 1'b1;
                    hash_raddr = probe_reg + HB'(1);
                    probe_next = probe_reg + HB'(1);
                    state_next = S_RD1;
                end else begin
                    push = 1'b1;
                    if (can_grow) begin
                        hash_we        = 1'b1;
                        str_we         = 1'b1;
                        next_free_next = next_free_reg + NF_W'(1);
                    end
                    prefix_next = CW'(byte_reg);
                    state_next  = fin_reg ? S_FLUSH : S_IDLE;
                end
            end
            S_FLUSH: begin
                push                 = 1'b1;
                push_item.stream_end = 1'b1;
                prefix_next          = '0;
                prefix_valid_next    = 1'b0;
                next_free_next       = NF_W'(FIRST_FREE);
                state_next           = S_IDLE;
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (hash_we) begin
            hash_mem[hash_waddr] <= hash_wdata;
        end
        if (hash_re) begin
            hash_q <= hash_mem[hash_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (str_we) begin
            str_mem[str_waddr] <= str_wdata;
        end
        if (str_re) begin
            str_q <= str_mem[str_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_CLEAR;
            prefix_reg       <= '0;
            prefix_valid_reg <= 1'b0;
            next_free_reg    <= NF_W'(FIRST_FREE);
            max_bits_reg     <= CFG_RESET;
            clr_reg          <= '0;
        end else begin
            state_reg        <= state_next;
            prefix_reg       <= prefix_next;
            prefix_valid_reg <= prefix_valid_next;
            next_free_reg    <= next_free_next;
            clr_reg          <= clr_next;
            if (cfg_wr_en) begin
                max_bits_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg  <= byte_next;
        fin_reg   <= fin_next;
        probe_reg <= probe_next;
    end

    // output queue
    assign m_tvalid = (cnt_reg != 3'd0);
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = {fifo_reg[rd_ptr_reg].code_width, fifo_reg[rd_ptr_reg].code};
    assign m_tlast  = fifo_reg[rd_ptr_reg].stream_end;

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + 3'(push) - 3'(pop);
        end
    end

    `LZWE_CHECK(a_fifo_bound, aclk, aresetn, 1'b1, cnt_reg <= 3'(FIFO_DEPTH), "output queue overflow")
    `LZWE_CHECK(a_free_bound, aclk, aresetn, 1'b1, next_free_reg <= NF_W'(TABLE_DEPTH), "next free code beyond table")
    `LZWE_CHECK_NEXT(a_first_byte, aclk, aresetn, accept && !prefix_valid_reg && !s_tlast, (state_reg == S_IDLE) && prefix_valid_reg, "first byte of a run not taken as prefix")
    `LZWE_CHECK_NEXT(a_grow_step, aclk, aresetn, insert, next_free_reg == $past(next_free_reg) + NF_W'(1), "table insert did not advance next free code")

endmodule
